/* sv/assert_macros.svh */
// Assertion helpers for the RTL of the fuse controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge; reset masks it.
`define OFAC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define OFAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ofac_pkg.sv */
// ----------------------------------------------------------------------------
// ofac_pkg
// Types, register map, command codes and helper functions of the OTP fuse
// array controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ofac_pkg;

  // Fuse store size in bytes
  localparam int ARRAY_BYTES = 1024;

  // Field widths of one item
  localparam int OP_W   = 2;
  localparam int IDX_W  = 10;
  localparam int WORD_W = 32;
  localparam int OFF_W  = 10;
  localparam int BYTE_W = 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2
  } op_t;

  // Register word indices
  localparam logic [IDX_W-1:0] REG_STATUS  = 10'd0;
  localparam logic [IDX_W-1:0] REG_ADDRESS = 10'd1;
  localparam logic [IDX_W-1:0] REG_DATA    = 10'd2;
  localparam logic [IDX_W-1:0] REG_LOCKCFG = 10'd3;
  localparam logic [IDX_W-1:0] REG_STRAP   = 10'd4;
  localparam logic [IDX_W-1:0] REG_CONTROL = 10'd5;

  // Status bits
  localparam logic [WORD_W-1:0] ST_READY = 32'h0000_0001;
  localparam logic [WORD_W-1:0] ST_DONE  = 32'h0000_0002;
  localparam logic [WORD_W-1:0] ST_RO    = ST_READY | ST_DONE;

  // Lock config fields
  localparam logic [WORD_W-1:0] CFG_DIS   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] CFG_LOCKS = 32'h00ff_0000;
  localparam logic [WORD_W-1:0] CFG_RESET = 32'h2000_0000;

  // Control and data register codes
  localparam logic [WORD_W-1:0] CMD_ARM  = 32'h0000_0001;
  localparam logic [WORD_W-1:0] CMD_READ = 32'h0000_0002;
  localparam logic [WORD_W-1:0] CMD_PROG = 32'hbf79_e5d0;
  localparam logic [WORD_W-1:0] DATA_CLR = 32'h0000_0001;

  // Nibble plus four parity bits in bits 4..7
  function automatic logic [BYTE_W-1:0] parity_nibble(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    r = {n[1] ^ n[3], n[0] ^ n[2], n[2] ^ n[3], n[0] ^ n[1], n};
    return r;
  endfunction

  // Sticky disable and lock bits; each lock bit freezes two config bits
  function automatic logic [WORD_W-1:0] next_lock_config(input logic [WORD_W-1:0] cur,
                                                         input logic [WORD_W-1:0] req);
    logic [WORD_W-1:0] frozen;
    logic [WORD_W-1:0] v;
    frozen = (cur & CFG_LOCKS) >> 8;
    frozen = frozen | (frozen >> 8);
    v = (cur & (CFG_DIS | CFG_LOCKS)) | (cur & frozen) | (req & ~frozen);
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/ofac_if.sv */
// ----------------------------------------------------------------------------
// ofac_if
// Valid/ready channels of the fuse controller: request, response and the
// mode configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one register access or preload per transfer
interface ofac_req_if import ofac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  reg_index;
  logic [WORD_W-1:0] write_data;
  logic [OFF_W-1:0]  load_offset;
  logic [BYTE_W-1:0] load_byte;

  modport source (output valid, operation, reg_index, write_data, load_offset,
                  load_byte, input ready);
  modport sink   (input valid, operation, reg_index, write_data, load_offset,
                  load_byte, output ready);
endinterface

// Response channel: one read value per request
interface ofac_rsp_if import ofac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// Configuration write channel: fuse array mode bit
interface ofac_cfg_if;
  logic valid;
  logic ready;
  logic fuse_array_mode;

  modport source (output valid, fuse_array_mode, input ready);
  modport sink   (input valid, fuse_array_mode, output ready);
endinterface

`default_nettype wire

/* sv/ofac_ram.sv */
// ----------------------------------------------------------------------------
// ofac_ram
// Simple dual-port RAM with per-bit write enables and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ofac_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wmask,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Masked write
  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/otp_fuse_array_controller_core.sv */
// ----------------------------------------------------------------------------
// otp_fuse_array_controller_core
// OTP fuse controller: 32-bit register file, byte read and bit program
// commands, preload of ECC-encoded bytes and a strap majority register.
// ----------------------------------------------------------------------------
// Each request goes from the input register through the combinational
// register file logic into the response register, so one transfer per cycle
// is taken while the response side is ready and no clearing pass runs; the
// input register can take one new request while a response waits. The fuse
// store is two bit-writable RAM banks (even and odd bytes), so a preload
// writes both of its bytes in the same cycle. After reset a clearing pass
// zeroes the banks, one row of each per cycle up to row 511, during which no
// request is taken; mode writes are taken at any time. A byte read command
// fetches the store through the registered RAM read and forwards it into the
// data register the cycle after, so a following read of the data register
// sees it without a stall. Store bytes 0..11 are mirrored in flops that feed
// the strap majority register.
`default_nettype none
`include "assert_macros.svh"

module otp_fuse_array_controller_core import ofac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ofac_req_if.sink   req,
  ofac_rsp_if.source rsp,
  ofac_cfg_if.sink   cfg
);

  localparam int BANK_DEPTH  = (ARRAY_BYTES + 1) / 2;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int STRAP_BYTES = 12;
  localparam logic [OFF_W:0]   ARRAY_LIMIT = (OFF_W + 1)'(ARRAY_BYTES);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(BANK_DEPTH - 1);

  // Architectural state
  logic              fuse_array_mode;
  logic [WORD_W-1:0] status_word, status_word_next;
  logic [WORD_W-1:0] address_word, address_word_next;
  logic [BYTE_W-1:0] data_byte, data_byte_next;
  logic [WORD_W-1:0] lock_config_word, lock_config_word_next;
  logic [WORD_W-1:0] key_index_word, key_index_word_next;
  logic              program_armed, program_armed_next;
  logic [BYTE_W-1:0] strap_mirror [STRAP_BYTES];
  logic [BYTE_W-1:0] strap_mirror_next [STRAP_BYTES];

  // Input register
  logic              s_valid;
  logic [OP_W-1:0]   s_op;
  logic [IDX_W-1:0]  s_idx;
  logic [WORD_W-1:0] s_wd;
  logic [OFF_W-1:0]  s_off;
  logic [BYTE_W-1:0] s_lb;

  // Response register
  logic              o_valid;
  logic [WORD_W-1:0] o_data;

  // Clearing pass
  logic              clearing;
  logic [ROW_W-1:0]  clr_row;

  // Pending byte read
  logic              data_pend, data_pend_next;
  logic              rd_bank, rd_bank_next;
  logic              rd_oob, rd_oob_next;

  // Bank ports
  logic              we_even, we_odd;
  logic [ROW_W-1:0]  wrow_even, wrow_odd;
  logic [BYTE_W-1:0] wmask_even, wmask_odd;
  logic [BYTE_W-1:0] wdata_even, wdata_odd;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_rrow;
  logic [BYTE_W-1:0] rdata_even, rdata_odd;

  logic              advance;
  logic [WORD_W-1:0] rd_value;
  logic [BYTE_W-1:0] data_eff;
  logic [WORD_W-1:0] strap_vote;
  logic [WORD_W-1:0] word_a, word_b, word_c;

  // Decoded operands
  logic [OFF_W-1:0]  byte_addr;
  logic [2:0]        bit_sel;
  logic              byte_in;
  logic [OFF_W:0]    off_p1;
  logic              load_in;
  logic [BYTE_W-1:0] enc_lo, enc_hi;
  logic [BYTE_W-1:0] bit_mask;

  assign advance  = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !clearing && (!s_valid || advance);
  assign cfg.ready = 1'b1;
  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_data;

  assign byte_addr = address_word[OFF_W-1:0];
  assign bit_sel   = address_word[OFF_W+2:OFF_W];
  assign byte_in   = {1'b0, byte_addr} < ARRAY_LIMIT;
  assign off_p1    = {1'b0, s_off} + (OFF_W + 1)'(1);
  assign load_in   = off_p1 < ARRAY_LIMIT;
  assign enc_lo    = parity_nibble(s_lb[3:0]);
  assign enc_hi    = parity_nibble(s_lb[7:4]);
  assign bit_mask  = BYTE_W'(1) << bit_sel;

  // Data register as seen this cycle: a byte read may have just returned
  assign data_eff = !data_pend ? data_byte :
                    rd_oob     ? '0 :
                    rd_bank    ? rdata_odd : rdata_even;

  // Strap majority of three little-endian words at bytes 0..11
  assign word_a = {strap_mirror[3], strap_mirror[2], strap_mirror[1], strap_mirror[0]};
  assign word_b = {strap_mirror[7], strap_mirror[6], strap_mirror[5], strap_mirror[4]};
  assign word_c = {strap_mirror[11], strap_mirror[10], strap_mirror[9], strap_mirror[8]};
  assign strap_vote = (word_a & word_b) | (word_a & word_c) | (word_b & word_c);

  // Register file read and update
  always_comb begin
    status_word_next      = status_word;
    address_word_next     = address_word;
    data_byte_next        = data_eff;
    lock_config_word_next = lock_config_word;
    key_index_word_next   = key_index_word;
    program_armed_next    = program_armed;
    strap_mirror_next     = strap_mirror;
    data_pend_next        = 1'b0;
    rd_bank_next          = rd_bank;
    rd_oob_next           = rd_oob;
    rd_value              = '0;
    mem_re                = 1'b0;
    mem_rrow              = byte_addr[ROW_W:1];
    we_even               = 1'b0;
    we_odd                = 1'b0;
    wrow_even             = s_off[ROW_W:1];
    wrow_odd              = s_off[ROW_W:1];
    wmask_even            = '1;
    wmask_odd             = '1;
    wdata_even            = enc_lo;
    wdata_odd             = enc_hi;

    if (clearing) begin
      // Zero one row of each bank
      we_even   = 1'b1;
      we_odd    = 1'b1;
      wrow_even = clr_row;
      wrow_odd  = clr_row;
      wdata_even = '0;
      wdata_odd  = '0;
    end else if (advance) begin
      unique case (op_t'(s_op))
        OP_READ: begin
          unique case (s_idx)
            REG_STATUS:  rd_value = status_word;
            REG_ADDRESS: rd_value = address_word;
            REG_DATA:    rd_value = {{(WORD_W - BYTE_W){1'b0}}, data_eff};
            REG_LOCKCFG: rd_value = lock_config_word;
            REG_STRAP:   rd_value = fuse_array_mode ? strap_vote : key_index_word;
            default:     rd_value = '0;
          endcase
        end
        OP_WRITE: begin
          unique case (s_idx)
            REG_STATUS: begin
              status_word_next = (s_wd & ~ST_RO) | (status_word & ST_READY) |
                                 (status_word & ST_DONE & ~(s_wd & ST_DONE));
            end
            REG_ADDRESS: address_word_next = s_wd;
            REG_DATA: begin
              if (s_wd == DATA_CLR) begin
                data_byte_next = '0;
              end
            end
            REG_LOCKCFG: lock_config_word_next = next_lock_config(lock_config_word, s_wd);
            REG_STRAP: begin
              if (!fuse_array_mode) begin
                key_index_word_next = s_wd;
              end
            end
            REG_CONTROL: begin
              if (s_wd == CMD_READ) begin
                // Byte read: data lands through the registered bank read
                mem_re           = 1'b1;
                data_pend_next   = 1'b1;
                rd_bank_next     = byte_addr[0];
                rd_oob_next      = !byte_in;
                status_word_next = status_word | ST_RO;
              end else if (s_wd == CMD_PROG && program_armed) begin
                // Program one bit of one byte
                if (byte_in) begin
                  we_even    = !byte_addr[0];
                  we_odd     = byte_addr[0];
                  wrow_even  = byte_addr[ROW_W:1];
                  wrow_odd   = byte_addr[ROW_W:1];
                  wmask_even = bit_mask;
                  wmask_odd  = bit_mask;
                  wdata_even = '1;
                  wdata_odd  = '1;
                  for (int i = 0; i < STRAP_BYTES; i++) begin
                    if (byte_addr == OFF_W'(i)) begin
                      strap_mirror_next[i] = strap_mirror[i] | bit_mask;
                    end
                  end
                end
                status_word_next = status_word | ST_RO;
              end
              program_armed_next = (s_wd == CMD_ARM);
            end
            default: ;
          endcase
        end
        OP_PRELOAD: begin
          if (load_in) begin
            we_even = 1'b1;
            we_odd  = 1'b1;
            if (!s_off[0]) begin
              wdata_even = enc_lo;
              wdata_odd  = enc_hi;
            end else begin
              wrow_even  = off_p1[ROW_W:1];
              wdata_even = enc_hi;
              wdata_odd  = enc_lo;
            end
            for (int i = 0; i < STRAP_BYTES; i++) begin
              if (s_off == OFF_W'(i)) begin
                strap_mirror_next[i] = enc_lo;
              end
              if (off_p1 == (OFF_W + 1)'(i)) begin
                strap_mirror_next[i] = enc_hi;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status_word      <= ST_READY;
      address_word     <= '0;
      data_byte        <= '0;
      lock_config_word <= CFG_RESET;
      key_index_word   <= '0;
      program_armed    <= 1'b0;
      data_pend        <= 1'b0;
      for (int i = 0; i < STRAP_BYTES; i++) begin
        strap_mirror[i] <= '0;
      end
    end else begin
      status_word      <= status_word_next;
      address_word     <= address_word_next;
      data_byte        <= data_byte_next;
      lock_config_word <= lock_config_word_next;
      key_index_word   <= key_index_word_next;
      program_armed    <= program_armed_next;
      data_pend        <= data_pend_next;
      strap_mirror     <= strap_mirror_next;
    end
  end

  // Pending read tags
  always_ff @(posedge clk) begin
    rd_bank <= rd_bank_next;
    rd_oob  <= rd_oob_next;
  end

  // Mode register, written on a configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      fuse_array_mode <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      fuse_array_mode <= cfg.fuse_array_mode;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + ROW_W'(1);
      if (clr_row == ROW_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_op  <= req.operation;
      s_idx <= req.reg_index;
      s_wd  <= req.write_data;
      s_off <= req.load_offset;
      s_lb  <= req.load_byte;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_data <= rd_value;
    end
  end

  // Fuse store banks: even and odd bytes
  ofac_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (BYTE_W)
  ) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (wrow_even),
    .wmask (wmask_even),
    .wdata (wdata_even),
    .re    (mem_re),
    .raddr (mem_rrow),
    .rdata (rdata_even)
  );

  ofac_ram #(
    .DEPTH (BANK_DEPTH),
    .WIDTH (BYTE_W)
  ) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (wrow_odd),
    .wmask (wmask_odd),
    .wdata (wdata_odd),
    .re    (mem_re),
    .raddr (mem_rrow),
    .rdata (rdata_odd)
  );

  // Checks
  `OFAC_ASSERT(a_clear_blocks_req, clk, rst, clearing |-> !req.ready, "request taken while clearing")
  `OFAC_ASSERT(a_nonread_zero, clk, rst, (advance && (s_op != OP_READ)) |=> (rsp.read_data == '0), "nonzero response for a non-read")
  `OFAC_ASSERT(a_ready_bit, clk, rst, status_word[0], "status ready bit lost")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the OTP fuse controller core against a cycle-free model of its
// register file and fuse store. Register reads, writes and byte preloads
// go in on the request channel, and every read value coming back is compared
// with the predicted one. The run covers both array modes, random stalls on
// both channels and one long response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ofac_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  reg_index;
    logic [WORD_W-1:0] write_data;
    logic [OFF_W-1:0]  load_offset;
    logic [BYTE_W-1:0] load_byte;
  } access_t;

  logic clk = 1'b0;
  logic rst;

  ofac_req_if req_ch ();
  ofac_rsp_if rsp_ch ();
  ofac_cfg_if cfg_ch ();

  otp_fuse_array_controller_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Queues: accesses waiting to go out, read values waiting to come back
  access_t           access_q[$];
  logic [WORD_W-1:0] read_data_q[$];
  access_t           cur_access;

  int   phase = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_rx = 1'b0;
  int   err_count = 0;
  int   cycle_count = 0;

  // Mirror of the block's state
  logic              array_mode;
  logic [WORD_W-1:0] m_status;
  logic [WORD_W-1:0] m_address;
  logic [BYTE_W-1:0] m_data;
  logic [WORD_W-1:0] m_lock;
  logic [WORD_W-1:0] m_key_index;
  logic              m_armed;
  logic [BYTE_W-1:0] m_fuse [ARRAY_BYTES];

  // Nibble with four parity bits on top
  function automatic logic [BYTE_W-1:0] ecc_nibble(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    r[3:0] = n;
    r[4]   = n[0] ^ n[1];
    r[5]   = n[2] ^ n[3];
    r[6]   = n[0] ^ n[2];
    r[7]   = n[1] ^ n[3];
    return r;
  endfunction

  // Apply one access to the mirror; returns the read value it yields
  function automatic logic [WORD_W-1:0] predict_read_data(input access_t a);
    logic [WORD_W-1:0] result;
    logic [WORD_W-1:0] frozen;
    logic [WORD_W-1:0] wa, wb, wc;
    logic [9:0]        byte_sel;
    logic [2:0]        bit_sel;
    result = '0;
    case (a.operation)
      OP_READ: begin
        case (a.reg_index)
          REG_STATUS:  result = m_status;
          REG_ADDRESS: result = m_address;
          REG_DATA:    result = {24'd0, m_data};
          REG_LOCKCFG: result = m_lock;
          REG_STRAP: begin
            if (array_mode) begin
              // majority of three little-endian words at bytes 0..11
              wa = {m_fuse[3], m_fuse[2], m_fuse[1], m_fuse[0]};
              wb = {m_fuse[7], m_fuse[6], m_fuse[5], m_fuse[4]};
              wc = {m_fuse[11], m_fuse[10], m_fuse[9], m_fuse[8]};
              result = (wa & wb) | (wa & wc) | (wb & wc);
            end else begin
              result = m_key_index;
            end
          end
          default: result = '0;
        endcase
      end
      OP_WRITE: begin
        case (a.reg_index)
          REG_STATUS: begin
            if ((a.write_data & ST_DONE) != '0) m_status = m_status & ~ST_DONE;
            m_status = (a.write_data & ~ST_RO) | (m_status & ST_RO);
          end
          REG_ADDRESS: m_address = a.write_data;
          REG_DATA: begin
            if (a.write_data == DATA_CLR) m_data = '0;
          end
          REG_LOCKCFG: begin
            // each lock bit 16+k freezes bits 8+k and k
            frozen = {16'd0, m_lock[23:16], m_lock[23:16]};
            m_lock = (m_lock & (CFG_DIS | CFG_LOCKS | frozen)) | (a.write_data & ~frozen);
          end
          REG_STRAP: begin
            if (!array_mode) m_key_index = a.write_data;
          end
          REG_CONTROL: begin
            // a 10-bit byte field always lands inside the 1 KiB store
            byte_sel = m_address[9:0];
            bit_sel  = m_address[12:10];
            if (a.write_data == CMD_READ) begin
              m_data   = m_fuse[byte_sel];
              m_status = m_status | ST_RO;
            end else if (a.write_data == CMD_PROG && m_armed) begin
              m_fuse[byte_sel][bit_sel] = 1'b1;
              m_status = m_status | ST_RO;
            end
            m_armed = (a.write_data == CMD_ARM);
          end
          default: ;
        endcase
      end
      OP_PRELOAD: begin
        if (int'(a.load_offset) + 1 < ARRAY_BYTES) begin
          m_fuse[a.load_offset]      = ecc_nibble(a.load_byte[3:0]);
          m_fuse[a.load_offset + 1]  = ecc_nibble(a.load_byte[7:4]);
        end
      end
      default: ;
    endcase
    return result;
  endfunction

  // Stimulus helpers; fields unused by an operation get random bits
  task automatic add_access(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] wd, input logic [OFF_W-1:0] off,
                            input logic [BYTE_W-1:0] lb);
    access_t a;
    a.operation   = op;
    a.reg_index   = idx;
    a.write_data  = wd;
    a.load_offset = off;
    a.load_byte   = lb;
    access_q.push_back(a);
  endtask

  task automatic reg_rd(input logic [IDX_W-1:0] idx);
    add_access(OP_READ, idx, $urandom, OFF_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic reg_wr(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] wd);
    add_access(OP_WRITE, idx, wd, OFF_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic preload(input logic [OFF_W-1:0] off, input logic [BYTE_W-1:0] lb);
    add_access(OP_PRELOAD, IDX_W'($urandom), $urandom, off, lb);
  endtask

  // Byte offset, half the time inside the strap words
  function automatic logic [9:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return 10'($urandom_range(0, 11));
    return 10'($urandom_range(0, ARRAY_BYTES - 1));
  endfunction

  // Extremes, each operation and the corner cases
  task automatic directed_accesses();
    reg_rd(REG_STATUS);
    reg_rd(REG_LOCKCFG);
    reg_rd(REG_STRAP);
    reg_rd(REG_CONTROL);
    reg_rd(10'h3ff);
    add_access(OP_UNUSED, 10'h3ff, 32'hffff_ffff, 10'h3ff, 8'hff);
    reg_wr(10'h3ff, 32'hffff_ffff);
    reg_wr(REG_STATUS, 32'hffff_ffff);
    reg_rd(REG_STATUS);
    preload(10'd0, 8'hff);
    preload(10'd1022, 8'h5a);
    preload(10'd1023, 8'hff);
    reg_wr(REG_ADDRESS, 32'h0000_1c02);
    reg_wr(REG_CONTROL, CMD_ARM);
    reg_wr(REG_CONTROL, CMD_PROG);
    reg_wr(REG_CONTROL, CMD_PROG);
    reg_wr(REG_CONTROL, CMD_READ);
    reg_rd(REG_DATA);
    reg_wr(REG_DATA, 32'hffff_ffff);
    reg_wr(REG_DATA, DATA_CLR);
    reg_wr(REG_CONTROL, 32'hffff_ffff);
    reg_wr(REG_STRAP, 32'hffff_ffff);
    reg_rd(REG_STRAP);
    reg_wr(REG_LOCKCFG, 32'h0001_ffff);
    reg_wr(REG_LOCKCFG, 32'h0000_0000);
    reg_rd(REG_LOCKCFG);
  endtask

  // Mostly well-formed command sequences, some broken ones and noise
  task automatic random_accesses(input int n_items);
    int start;
    logic [WORD_W-1:0] wd;
    logic [IDX_W-1:0]  idx;
    start = access_q.size();
    while (access_q.size() - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // arm and program one bit, then read it back
          wd = $urandom;
          wd[9:0] = pick_byte();
          reg_wr(REG_ADDRESS, wd);
          if ($urandom_range(0, 4) != 0) reg_wr(REG_CONTROL, CMD_ARM);
          if ($urandom_range(0, 4) == 0) reg_wr(REG_CONTROL, $urandom);
          reg_wr(REG_CONTROL, CMD_PROG);
          reg_rd(REG_STATUS);
          if ($urandom_range(0, 1) == 0) reg_wr(REG_STATUS, $urandom);
          reg_wr(REG_CONTROL, CMD_READ);
          reg_rd(REG_DATA);
          if ($urandom_range(0, 2) == 0) reg_rd(REG_STRAP);
        end
        3, 4: begin
          // byte read and data clear
          wd = $urandom;
          wd[9:0] = pick_byte();
          reg_wr(REG_ADDRESS, wd);
          reg_wr(REG_CONTROL, CMD_READ);
          reg_rd(REG_DATA);
          reg_wr(REG_DATA, ($urandom_range(0, 1) == 0) ? DATA_CLR : $urandom);
          reg_rd(REG_DATA);
          reg_rd(REG_ADDRESS);
        end
        5: begin
          // preload, possibly at the end of the store, then the strap word
          if ($urandom_range(0, 3) == 0)
            preload(10'($urandom_range(1020, 1023)), BYTE_W'($urandom));
          else preload(pick_byte(), BYTE_W'($urandom));
          reg_rd(REG_STRAP);
        end
        6: begin
          // lock config; lock bits set only now and then since they stick
          wd = $urandom & ~CFG_LOCKS;
          if ($urandom_range(0, 24) == 0) wd[16 + $urandom_range(0, 7)] = 1'b1;
          if ($urandom_range(0, 1) == 0) wd[31] = 1'b0;
          reg_wr(REG_LOCKCFG, wd);
          reg_rd(REG_LOCKCFG);
        end
        7: begin
          reg_wr(REG_STRAP, $urandom);
          reg_rd(REG_STRAP);
        end
        default: begin
          idx = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
          wd = $urandom;
          if (idx == REG_LOCKCFG) wd = wd & ~CFG_LOCKS;
          add_access(2'($urandom_range(0, 3)), idx, wd, OFF_W'($urandom),
                     BYTE_W'($urandom));
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (access_q.size() != 0 || req_ch.valid || read_data_q.size() != 0) @(negedge clk);
  endtask

  // Mode write, only while the block is idle
  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.fuse_array_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    array_mode <= m;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic log_mismatch(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    err_count++;
    if (err_count <= 10) $display("mismatch (%s): expected %h, got %h", what, want, got);
  endtask

  // Request driver: predicts on each transfer, holds an item until taken
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        read_data_q.push_back(predict_read_data(cur_access));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_access = access_q.pop_front();
          req_ch.operation   <= cur_access.operation;
          req_ch.reg_index   <= cur_access.reg_index;
          req_ch.write_data  <= cur_access.write_data;
          req_ch.load_offset <= cur_access.load_offset;
          req_ch.load_byte   <= cur_access.load_byte;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (read_data_q.size() == 0) log_mismatch("unexpected", '0, rsp_ch.read_data);
        else if (read_data_q[0] !== rsp_ch.read_data)
          log_mismatch("read_data", read_data_q[0], rsp_ch.read_data);
        if (read_data_q.size() != 0) void'(read_data_q.pop_front());
      end
      rsp_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long response hold-off in the last phase so the block backs up
  initial begin
    wait (phase == 2);
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sequencer: reset, then three phases with different mode and stalls
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.reg_index = '0;
    req_ch.write_data = '0;
    req_ch.load_offset = '0;
    req_ch.load_byte = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.fuse_array_mode = 1'b1;
    array_mode = 1'b1;
    m_status = ST_READY;
    m_address = '0;
    m_data = '0;
    m_lock = CFG_RESET;
    m_key_index = '0;
    m_armed = 1'b0;
    foreach (m_fuse[i]) m_fuse[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender rarely idle, receiver mostly stalled; fuse-array mode
    write_mode(1'b1);
    @(negedge clk);
    send_idle_pct = 8;
    recv_idle_pct = 66;
    directed_accesses();
    random_accesses(520);
    wait_idle();

    // the other way round; key mode
    write_mode(1'b0);
    @(negedge clk);
    phase = 1;
    send_idle_pct = 66;
    recv_idle_pct = 8;
    random_accesses(540);
    wait_idle();

    // no idling, one long hold-off; back to fuse-array mode
    write_mode(1'b1);
    @(negedge clk);
    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_accesses(540);
    wait_idle();

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* otp_fuse_array_controller_core.f */
+incdir+sv
sv/ofac_pkg.sv
sv/ofac_if.sv
sv/ofac_ram.sv
sv/otp_fuse_array_controller_core.sv
tb/testbench.sv
